### hw/rtl/asc_pkg.sv
`timescale 1ns / 1ps

package asc_pkg;

    localparam int C_ANGLE_BITS    = 32;
    localparam int C_FRACTION_BITS = 30;

    // internal binary angle, 2^31 is pi
    localparam int C_BAM_BITS = 32;
    // CORDIC angle accumulator, one guard bit over the binary angle
    localparam int C_ZW       = 33;
    localparam int C_STEPS    = 31;

    localparam logic [63:0] C_GAIN_INV_Q30 = 64'd652032874;

    localparam logic [C_BAM_BITS-1:0] C_EIGHTH_TURN  = 32'h2000_0000;
    localparam logic [C_BAM_BITS-1:0] C_QUARTER_TURN = 32'h4000_0000;

    // atan(2^-i) in binary angle units
    localparam logic [31:0] C_ATAN [C_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1
    };

    // pipeline advance and the valid bit entering a unit
    typedef struct packed {
        logic ce;
        logic valid;
    } t_pipe;

endpackage

### hw/rtl/asc_if.sv
`timescale 1ns / 1ps

interface asc_pair_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] lon_a;
    logic signed [W-1:0] lat_a;
    logic signed [W-1:0] lon_b;
    logic signed [W-1:0] lat_b;

    modport source (output valid, output lon_a, output lat_a, output lon_b, output lat_b,
                    input ready);
    modport sink   (input valid, input lon_a, input lat_a, input lon_b, input lat_b,
                    output ready);
endinterface

interface asc_sep_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] separation;

    modport source (output valid, output separation, input ready);
    modport sink   (input valid, input separation, output ready);
endinterface

### hw/rtl/asc_sincos.sv
`timescale 1ns / 1ps

module asc_sincos
    import asc_pkg::*;
#(
    parameter int W = 33,
    parameter int F = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pipe                 i_ctl,
    input  logic [C_BAM_BITS-1:0] i_angle,
    output logic                  o_valid,
    output logic signed [W-1:0]   o_cos,
    output logic signed [W-1:0]   o_sin
);

    localparam int KSL = (F >= 30) ? F - 30 : 0;
    localparam int KSR = (F >= 30) ? 0 : 30 - F;
    localparam logic [63:0] KQ = (C_GAIN_INV_Q30 << KSL) >> KSR;
    localparam logic signed [W-1:0] K = W'(KQ);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic                   r_v [0:C_STEPS];
    logic [1:0]             r_q [0:C_STEPS];
    logic signed [W-1:0]    r_x [0:C_STEPS];
    logic signed [W-1:0]    r_y [0:C_STEPS];
    logic signed [C_ZW-1:0] r_z [0:C_STEPS];

    logic [1:0]            n_q0;
    logic [C_BAM_BITS-1:0] n_d0;

    // fold into [-pi/4, pi/4) by quarter turns
    always_comb begin
        n_q0 = 2'((i_angle + C_EIGHTH_TURN) >> 30);
        n_d0 = i_angle - {n_q0, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.ce) begin
            r_v[0] <= i_ctl.valid;
        end
        if (i_ctl.ce) begin
            r_q[0] <= n_q0;
            r_z[0] <= {n_d0[C_BAM_BITS-1], n_d0};
            r_x[0] <= K;
            r_y[0] <= '0;
        end
    end

    for (genvar i = 0; i < C_STEPS; i++) begin : g_iter
        logic signed [W-1:0]    n_x;
        logic signed [W-1:0]    n_y;
        logic signed [C_ZW-1:0] n_z;

        always_comb begin
            if (!r_z[i][C_ZW-1]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - $signed(C_ZW'(C_ATAN[i]));
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + $signed(C_ZW'(C_ATAN[i]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_ctl.ce) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_ctl.ce) begin
                r_q[i+1] <= r_q[i];
                r_x[i+1] <= n_x;
                r_y[i+1] <= n_y;
                r_z[i+1] <= n_z;
            end
        end
    end

    logic signed [W-1:0] n_cos;
    logic signed [W-1:0] n_sin;
    logic                r_out_v;
    logic signed [W-1:0] r_cos;
    logic signed [W-1:0] r_sin;

    always_comb begin
        case (r_q[C_STEPS])
            QUAD_0: begin
                n_cos = r_x[C_STEPS];
                n_sin = r_y[C_STEPS];
            end
            QUAD_1: begin
                n_cos = -r_y[C_STEPS];
                n_sin = r_x[C_STEPS];
            end
            QUAD_2: begin
                n_cos = -r_x[C_STEPS];
                n_sin = -r_y[C_STEPS];
            end
            default: begin
                n_cos = r_y[C_STEPS];
                n_sin = -r_x[C_STEPS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_ctl.ce) begin
            r_out_v <= r_v[C_STEPS];
        end
        if (i_ctl.ce) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_valid = r_out_v;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

### hw/rtl/asc_mulq.sv
`timescale 1ns / 1ps

module asc_mulq
    import asc_pkg::*;
#(
    parameter int W     = 33,
    parameter int F     = 30,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe               i_ctl,
    input  logic signed [W-1:0] i_a [LANES],
    input  logic signed [W-1:0] i_b [LANES],
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic signed [W-1:0] o_p [LANES],
    output logic [SW-1:0]       o_side
);

    // sign-magnitude product, magnitude truncated to F fraction bits
    logic          r_v1, r_v2, r_v3;
    logic [SW-1:0] r_s1, r_s2, r_s3;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [W-1:0]        r_ma;
        logic [W-1:0]        r_mb;
        logic                r_neg1;
        logic [2*W-1:0]      n_prod;
        logic [W-1:0]        r_mp;
        logic                r_neg2;
        logic signed [W-1:0] r_p;

        assign n_prod = r_ma * r_mb;

        always_ff @(posedge i_clk) begin
            if (i_ctl.ce) begin
                r_ma   <= i_a[l][W-1] ? W'(-i_a[l]) : W'(i_a[l]);
                r_mb   <= i_b[l][W-1] ? W'(-i_b[l]) : W'(i_b[l]);
                r_neg1 <= i_a[l][W-1] ^ i_b[l][W-1];
                r_mp   <= W'(n_prod >> F);
                r_neg2 <= r_neg1;
                r_p    <= r_neg2 ? -$signed(r_mp) : $signed(r_mp);
            end
        end

        assign o_p[l] = r_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ctl.ce) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_ctl.ce) begin
            r_s1 <= i_side;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_s3;

endmodule

### hw/rtl/asc_sqrt.sv
`timescale 1ns / 1ps

module asc_sqrt
    import asc_pkg::*;
#(
    parameter int N  = 32,
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_pipe          i_ctl,
    input  logic [2*N-1:0] i_rad,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output logic [N-1:0]   o_root,
    output logic [SW-1:0]  o_side
);

    // digit-by-digit floor square root, one root bit per stage
    logic           r_v    [0:N];
    logic [2*N-1:0] r_rad  [0:N-1];
    logic [N+1:0]   r_rem  [0:N];
    logic [N-1:0]   r_root [0:N];
    logic [SW-1:0]  r_side [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.ce) begin
            r_v[0] <= i_ctl.valid;
        end
        if (i_ctl.ce) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_digit
        logic [N+2:0] n_t;
        logic [N+2:0] n_trial;
        logic         n_take;

        // remainder stays below 2*root+1, so its top bit is always clear
        always_comb begin
            n_t     = {r_rem[k][N:0], r_rad[k][2*N-1 -: 2]};
            n_trial = (N+3)'({r_root[k], 2'b01});
            n_take  = (n_t >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ctl.ce) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_ctl.ce) begin
                r_side[k+1] <= r_side[k];
                if (n_take) begin
                    r_rem[k+1]  <= (N+2)'(n_t - n_trial);
                    r_root[k+1] <= {r_root[k][N-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= (N+2)'(n_t);
                    r_root[k+1] <= {r_root[k][N-2:0], 1'b0};
                end
            end
        end

        if (k < N - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_ctl.ce) begin
                    r_rad[k+1] <= r_rad[k] << 2;
                end
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_root[N];
    assign o_side  = r_side[N];

endmodule

### hw/rtl/asc_vec.sv
`timescale 1ns / 1ps

module asc_vec
    import asc_pkg::*;
#(
    parameter int W = 33
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe               i_ctl,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    output logic                o_valid,
    output logic [30:0]         o_angle
);

    // vectoring CORDIC: angle of (x, y), clamped to [0, pi/2]
    localparam logic signed [C_ZW-1:0] ZMAX = $signed(C_ZW'(C_QUARTER_TURN));

    logic                   r_v [0:C_STEPS];
    logic signed [W-1:0]    r_x [0:C_STEPS];
    logic signed [W-1:0]    r_y [0:C_STEPS];
    logic signed [C_ZW-1:0] r_z [0:C_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.ce) begin
            r_v[0] <= i_ctl.valid;
        end
        if (i_ctl.ce) begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < C_STEPS; i++) begin : g_iter
        logic signed [W-1:0]    n_x;
        logic signed [W-1:0]    n_y;
        logic signed [C_ZW-1:0] n_z;

        always_comb begin
            if (!r_y[i][W-1]) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + $signed(C_ZW'(C_ATAN[i]));
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - $signed(C_ZW'(C_ATAN[i]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_ctl.ce) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_ctl.ce) begin
                r_x[i+1] <= n_x;
                r_y[i+1] <= n_y;
                r_z[i+1] <= n_z;
            end
        end
    end

    logic        r_out_v;
    logic [30:0] r_angle;
    logic [30:0] n_angle;

    always_comb begin
        if (r_z[C_STEPS][C_ZW-1]) begin
            n_angle = '0;
        end else if (r_z[C_STEPS] > ZMAX) begin
            n_angle = 31'(C_QUARTER_TURN);
        end else begin
            n_angle = r_z[C_STEPS][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_ctl.ce) begin
            r_out_v <= r_v[C_STEPS];
        end
        if (i_ctl.ce) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_out_v;
    assign o_angle = r_angle;

endmodule

### hw/rtl/angular_separation_chord.sv
`timescale 1ns / 1ps

// Central angle between two sphere positions by the chord method. Each request
// carries two longitude/latitude pairs as binary angles (2^(ANGLE_BITS-1) is pi);
// the result is the separation in [0, pi] in the same units. The datapath is one
// long pipeline: four sin/cos CORDICs, sign-magnitude multipliers, a bit-per-stage
// square root for the chord, a second one for sqrt(1 - h^2) and a vectoring
// CORDIC for the arcsine. It takes one request every cycle while the output is empty
// or taken; most of its depth lies in the two 31-step CORDICs and the two square
// roots. When the result is not taken the whole pipeline holds.
module angular_separation_chord
    import asc_pkg::*;
#(
    parameter int ANGLE_BITS    = C_ANGLE_BITS,
    parameter int FRACTION_BITS = C_FRACTION_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    asc_pair_if.sink        i_pair,
    asc_sep_if.source       o_sep
);

    localparam int F   = FRACTION_BITS;
    localparam int W   = F + 3;
    localparam int SQW = F + 4;
    localparam int N1  = F + 2;
    localparam int N2  = F + 1;
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    function automatic logic [C_BAM_BITS-1:0] to_bam(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS+C_BAM_BITS-1:0] t;
        t = {a, {C_BAM_BITS{1'b0}}};
        return t[ANGLE_BITS+C_BAM_BITS-1 -: C_BAM_BITS];
    endfunction

    function automatic logic [ANGLE_BITS-1:0] from_bam(input logic [C_BAM_BITS-1:0] a);
        logic [ANGLE_BITS+C_BAM_BITS-1:0] t;
        t = {a, {ANGLE_BITS{1'b0}}};
        return t[ANGLE_BITS+C_BAM_BITS-1 -: ANGLE_BITS];
    endfunction

    logic  w_ce;
    logic  r_out_v;
    logic [ANGLE_BITS-1:0] r_sep;

    assign w_ce         = !r_out_v || o_sep.ready;
    assign i_pair.ready = w_ce;

    // sin/cos of lon_a, lat_a, lon_b, lat_b
    logic [C_BAM_BITS-1:0] w_bam   [4];
    logic                  w_sc_v  [4];
    logic signed [W-1:0]   w_cos   [4];
    logic signed [W-1:0]   w_sin   [4];

    assign w_bam[0] = to_bam(i_pair.lon_a);
    assign w_bam[1] = to_bam(i_pair.lat_a);
    assign w_bam[2] = to_bam(i_pair.lon_b);
    assign w_bam[3] = to_bam(i_pair.lat_b);

    for (genvar j = 0; j < 4; j++) begin : g_sc
        asc_sincos #(.W(W), .F(F)) u_sincos (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ('{ce: w_ce, valid: i_pair.valid}),
            .i_angle (w_bam[j]),
            .o_valid (w_sc_v[j]),
            .o_cos   (w_cos[j]),
            .o_sin   (w_sin[j])
        );
    end

    // unit vector x and y components of both points
    logic signed [W-1:0] w_m1_a [4];
    logic signed [W-1:0] w_m1_b [4];
    logic signed [W-1:0] w_m1_p [4];
    logic [2*W-1:0]      w_m1_side;
    logic                w_m1_v;

    always_comb begin
        w_m1_a[0] = w_cos[1];
        w_m1_b[0] = w_cos[0];
        w_m1_a[1] = w_cos[1];
        w_m1_b[1] = w_sin[0];
        w_m1_a[2] = w_cos[3];
        w_m1_b[2] = w_cos[2];
        w_m1_a[3] = w_cos[3];
        w_m1_b[3] = w_sin[2];
    end

    asc_mulq #(.W(W), .F(F), .LANES(4), .SW(2*W)) u_mul_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{ce: w_ce, valid: w_sc_v[0] & w_sc_v[1] & w_sc_v[2] & w_sc_v[3]}),
        .i_a     (w_m1_a),
        .i_b     (w_m1_b),
        .i_side  ({w_sin[1], w_sin[3]}),
        .o_valid (w_m1_v),
        .o_p     (w_m1_p),
        .o_side  (w_m1_side)
    );

    // chord vector
    logic                r_d_v;
    logic signed [W-1:0] r_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_ce) begin
            r_d_v <= w_m1_v;
        end
        if (w_ce) begin
            r_d[0] <= w_m1_p[2] - w_m1_p[0];
            r_d[1] <= w_m1_p[3] - w_m1_p[1];
            r_d[2] <= $signed(w_m1_side[W-1:0]) - $signed(w_m1_side[2*W-1:W]);
        end
    end

    logic signed [W-1:0] w_dd [3];
    logic                w_dd_v;

    asc_mulq #(.W(W), .F(F), .LANES(3), .SW(1)) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{ce: w_ce, valid: r_d_v}),
        .i_a     (r_d),
        .i_b     (r_d),
        .i_side  (1'b0),
        .o_valid (w_dd_v),
        .o_p     (w_dd),
        .o_side  ()
    );

    logic           r_sq_v;
    logic [SQW-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (w_ce) begin
            r_sq_v <= w_dd_v;
        end
        if (w_ce) begin
            r_sq <= SQW'(unsigned'(w_dd[0])) + SQW'(unsigned'(w_dd[1]))
                  + SQW'(unsigned'(w_dd[2]));
        end
    end

    logic          w_chord_v;
    logic [N1-1:0] w_chord;

    asc_sqrt #(.N(N1), .SW(1)) u_sqrt_chord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{ce: w_ce, valid: r_sq_v}),
        .i_rad   ({r_sq, {F{1'b0}}}),
        .i_side  (1'b0),
        .o_valid (w_chord_v),
        .o_root  (w_chord),
        .o_side  ()
    );

    // half chord, saturated to one
    logic       r_h_v;
    logic [F:0] r_h;
    logic [F:0] n_h;

    assign n_h = w_chord[N1-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (w_ce) begin
            r_h_v <= w_chord_v;
        end
        if (w_ce) begin
            r_h <= (n_h > ONE) ? ONE : n_h;
        end
    end

    logic signed [W-1:0] w_h_s  [1];
    logic signed [W-1:0] w_hh   [1];
    logic [F:0]          w_hh_h;
    logic                w_hh_v;

    assign w_h_s[0] = $signed(W'(r_h));

    asc_mulq #(.W(W), .F(F), .LANES(1), .SW(F+1)) u_mul_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{ce: w_ce, valid: r_h_v}),
        .i_a     (w_h_s),
        .i_b     (w_h_s),
        .i_side  (r_h),
        .o_valid (w_hh_v),
        .o_p     (w_hh),
        .o_side  (w_hh_h)
    );

    logic       r_u_v;
    logic [F:0] r_u;
    logic [F:0] r_uh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else if (w_ce) begin
            r_u_v <= w_hh_v;
        end
        if (w_ce) begin
            r_u  <= ONE - (F+1)'(unsigned'(w_hh[0]));
            r_uh <= w_hh_h;
        end
    end

    logic          w_cx_v;
    logic [N2-1:0] w_cx;
    logic [F:0]    w_cx_h;

    asc_sqrt #(.N(N2), .SW(F+1)) u_sqrt_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{ce: w_ce, valid: r_u_v}),
        .i_rad   ({1'b0, r_u, {F{1'b0}}}),
        .i_side  (r_uh),
        .o_valid (w_cx_v),
        .o_root  (w_cx),
        .o_side  (w_cx_h)
    );

    logic        w_ang_v;
    logic [30:0] w_ang;

    asc_vec #(.W(W)) u_asin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{ce: w_ce, valid: w_cx_v}),
        .i_x     ($signed(W'(w_cx))),
        .i_y     ($signed(W'(w_cx_h))),
        .o_valid (w_ang_v),
        .o_angle (w_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_ce) begin
            r_out_v <= w_ang_v;
        end
        if (w_ce) begin
            r_sep <= from_bam({w_ang, 1'b0});
        end
    end

    assign o_sep.valid      = r_out_v;
    assign o_sep.separation = r_sep;

`ifndef NO_ASSERTIONS
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sep.valid |-> i_pair.ready)
        else $error("input stalled with empty output stage");

    a_sep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sep.valid |-> o_sep.separation <= HALF_TURN)
        else $error("separation above half turn");

    a_h_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h_v |-> r_h <= ONE)
        else $error("half chord not saturated");

    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u_v |-> r_u <= ONE)
        else $error("1 - h^2 out of range");
`endif

endmodule
